FILE: hdl/shr_pkg.sv
// Shared types and constants for the shape rasterizer.
`timescale 1ns / 1ps
package shr_pkg;
  localparam int unsigned MaxSide = 512;
  localparam int unsigned CoordW = $clog2(MaxSide);
  localparam int unsigned AddrW = 2 * CoordW;
  localparam int unsigned PixW = 24;

  typedef enum logic [2:0] {
    CmdClear = 3'd0, CmdCircle = 3'd1, CmdRect = 3'd2,
    CmdTri = 3'd3, CmdDots = 3'd4, CmdRead = 3'd5,
    CmdRsvd6 = 3'd6, CmdRsvd7 = 3'd7
  } cmd_e;

  localparam logic [23:0] ClearGray = 24'hE6E6E6;
  localparam logic [23:0] DotColour = 24'h0A0A0A;
  localparam logic [6:0] DotMod = 7'd97;
  localparam logic [6:0] DotStepX = 7'd17;
  localparam logic [6:0] DotStepY = 7'd31;

  typedef struct packed {
    logic [2:0] command;
    logic signed [11:0] first_x;
    logic signed [11:0] first_y;
    logic signed [11:0] second_x;
    logic signed [11:0] second_y;
    logic signed [11:0] third_x;
    logic signed [11:0] third_y;
    logic [10:0] radius;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } out_item_t;
endpackage

FILE: hdl/shape_rasterizer.sv
// Top level of the shape rasterizer: command sequencer, pixel scan and framebuffer.
`timescale 1ns / 1ps
// Each drawing command scans its clipped bounding box one pixel per clock, writing
// the single-port framebuffer as it goes. A clear scans the whole MaxSide*MaxSide
// memory, a dot overlay the side*side square; a command with an empty box or a
// reserved code scans nothing, and a read is held while an earlier result still
// waits for the receiver. The framebuffer port sets the rate. One command is
// handled at a time; the read result sits in an output register so the next command
// is taken while it waits. Pixel colour per the command; reads outside the square
// return zero.
module shape_rasterizer import shr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      psel,
  input  logic      penable,
  input  logic      pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic      pready
);
  localparam logic [2:0] StIdle = 3'd0, StSetup = 3'd1, StScan = 3'd2,
                         StRdWait = 3'd3, StRdTake = 3'd4, StSetup2 = 3'd5;

  logic [2:0] state_q, state_d;
  logic [9:0] side_q;
  in_item_t cmd_q;
  logic signed [12:0] x_q, y_q, x0_q, x1_q, y1_q;
  logic [6:0] dot_q, dotrow_q;
  logic signed [24:0] e1a_q, e1b_q, e2a_q, e2b_q, e3a_q, e3b_q;
  logic signed [24:0] rr_q;
  logic rd_ok_q;
  logic ov_q;
  out_item_t od_q;

  // APB register
  assign pready = 1'b1;
  assign prdata = {22'd0, side_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) side_q <= 10'd512;
    else if (psel && penable && pwrite && paddr == 2'd0) side_q <= pwdata[9:0];
  end

  logic signed [12:0] s_act, smax;
  assign s_act = (side_q > 10'(MaxSide - 1) && MaxSide <= 1023) ?
                 13'(MaxSide) : 13'(side_q);
  assign smax = s_act - 13'sd1;

  function automatic logic signed [12:0] lo(input logic signed [12:0] v);
    return v < 0 ? 13'sd0 : v;
  endfunction
  function automatic logic signed [12:0] mn(input logic signed [12:0] a, b);
    return a < b ? a : b;
  endfunction
  function automatic logic signed [12:0] mx(input logic signed [12:0] a, b);
    return a > b ? a : b;
  endfunction

  logic signed [12:0] ax, ay, bx, by, cx, cy, rd;
  assign ax = 13'(cmd_q.first_x);  assign ay = 13'(cmd_q.first_y);
  assign bx = 13'(cmd_q.second_x); assign by = 13'(cmd_q.second_y);
  assign cx = 13'(cmd_q.third_x);  assign cy = 13'(cmd_q.third_y);
  assign rd = 13'(signed'({2'b0, cmd_q.radius}));

  // per-pixel tests
  logic signed [13:0] dx, dy;
  logic signed [27:0] d2;
  assign dx = 14'(x_q) - 14'(cx);
  assign dy = 14'(y_q) - 14'(cy);
  assign d2 = 28'(dx * dx) + 28'(dy * dy);
  logic signed [26:0] f1, f2, f3;
  // edge(p,a,b) = (px-bx)(ay-by)-(ax-bx)(py-by): linear form px*A + py*B + C
  assign f1 = 27'(e1a_q * 27'(x_q)) + 27'(e1b_q * 27'(y_q));
  assign f2 = 27'(e2a_q * 27'(x_q)) + 27'(e2b_q * 27'(y_q));
  assign f3 = 27'(e3a_q * 27'(x_q)) + 27'(e3b_q * 27'(y_q));
  logic signed [26:0] c1_q, c2_q, c3_q;
  logic signed [26:0] g1, g2, g3;
  assign g1 = f1 + c1_q; assign g2 = f2 + c2_q; assign g3 = f3 + c3_q;
  logic neg, pos, hit;
  assign neg = g1 < 0 || g2 < 0 || g3 < 0;
  assign pos = g1 > 0 || g2 > 0 || g3 > 0;
  always_comb begin
    unique case (cmd_e'(cmd_q.command))
      CmdCircle: hit = d2 <= 28'(rr_q);
      CmdTri:    hit = !(neg && pos);
      CmdDots:   hit = dot_q == 7'd0;
      default:   hit = 1'b1;
    endcase
  end

  logic we;
  logic [AddrW-1:0] addr;
  logic [PixW-1:0] wdata, rdata;
  assign we = state_q == StScan && hit;
  assign wdata = cmd_q.command == CmdClear ? ClearGray :
                 cmd_q.command == CmdDots ? DotColour :
                 {cmd_q.red, cmd_q.green, cmd_q.blue};
  assign addr = {y_q[CoordW-1:0], x_q[CoordW-1:0]};

  shr_ram #(.Width(PixW), .Depth(MaxSide * MaxSide)) u_fb (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  assign in_stall_o = state_q != StIdle;
  assign out_valid_o = ov_q;
  assign out_data_o = od_q;

  logic row_end, last;
  assign row_end = x_q >= x1_q;
  assign last = row_end && y_q >= y1_q;

  function automatic logic [6:0] madd(input logic [6:0] a, input logic [6:0] b);
    logic [7:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s >= {1'b0, DotMod} ? 7'(s - {1'b0, DotMod}) : s[6:0];
  endfunction

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_valid_i) state_d = StSetup;
      StSetup:  state_d = StSetup2;
      StSetup2: begin
        priority if (cmd_q.command == CmdRead) state_d = StRdWait;
        else if (x0_q > x1_q || y_q > y1_q || cmd_q.command > CmdRead) state_d = StIdle;
        else state_d = StScan;
      end
      StScan:   if (last) state_d = StIdle;
      StRdWait: state_d = StRdTake;
      StRdTake: if (!(ov_q && out_stall_i)) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StRdTake && !(ov_q && out_stall_i)) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: if (in_valid_i) cmd_q <= in_data_i;
      StSetup: begin
        rr_q <= 25'(rd * rd);
        e1a_q <= 25'(ay - by); e1b_q <= 25'(bx - ax);
        e2a_q <= 25'(by - cy); e2b_q <= 25'(cx - bx);
        e3a_q <= 25'(cy - ay); e3b_q <= 25'(ax - cx);
        unique case (cmd_e'(cmd_q.command))
          CmdClear: begin
            x0_q <= 13'sd0; y_q <= 13'sd0;
            x1_q <= 13'(MaxSide - 1); y1_q <= 13'(MaxSide - 1);
          end
          CmdCircle: begin
            x0_q <= lo(cx - rd); x1_q <= mn(cx + rd, smax);
            y_q <= lo(cy - rd); y1_q <= mn(cy + rd, smax);
          end
          CmdRect: begin
            x0_q <= lo(ax); x1_q <= mn(bx, smax);
            y_q <= lo(ay); y1_q <= mn(by, smax);
          end
          CmdTri: begin
            x0_q <= lo(mn(mn(ax, bx), cx)); x1_q <= mn(mx(mx(ax, bx), cx), smax);
            y_q <= lo(mn(mn(ay, by), cy)); y1_q <= mn(mx(mx(ay, by), cy), smax);
          end
          CmdDots: begin
            x0_q <= 13'sd0; y_q <= 13'sd0; x1_q <= smax; y1_q <= smax;
          end
          default: begin
            x0_q <= ax; y_q <= ay; x1_q <= ax; y1_q <= ay;
          end
        endcase
        rd_ok_q <= ax >= 0 && ay >= 0 && ax < s_act && ay < s_act;
      end
      StSetup2: begin
        x_q <= x0_q;
        dot_q <= 7'd0; dotrow_q <= 7'd0;
        // constant terms: edge at origin
        c1_q <= 27'(e1b_q * 27'(by) * -1) - 27'(e1a_q * 27'(bx));
        c2_q <= 27'(e2b_q * 27'(cy) * -1) - 27'(e2a_q * 27'(cx));
        c3_q <= 27'(e3b_q * 27'(ay) * -1) - 27'(e3a_q * 27'(ax));
      end
      StScan: begin
        if (row_end) begin
          x_q <= x0_q; y_q <= y_q + 13'sd1;
          dotrow_q <= madd(dotrow_q, DotStepY); dot_q <= madd(dotrow_q, DotStepY);
        end else begin
          x_q <= x_q + 13'sd1; dot_q <= madd(dot_q, DotStepX);
        end
      end
      StRdTake: if (!(ov_q && out_stall_i)) od_q <= rd_ok_q ? rdata : '0;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> in_stall_o) else $error("input taken mid scan");
  a_we_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> state_q == StScan) else $error("write outside scan");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result lost");
`endif
endmodule

FILE: hdl/shr_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module shr_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: verif/tb_shape_rasterizer.sv
// Self-checking testbench for the shape rasterizer: drawing commands, pixel reads, clipping.
`timescale 1ns / 1ps
module tb_shape_rasterizer;
  import shr_pkg::*;

  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned HoldCycles = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  shape_rasterizer u_dut (.*);

  always #1 clk_i = ~clk_i;

  // Shadow framebuffer and side register
  logic [23:0] shadow_fb [MaxSide*MaxSide];
  int          shadow_side = 512;
  out_item_t   pixel_expect_q[$];

  int  fail_count = 0;
  int  cmds_sent = 0;
  int  pixels_checked = 0;
  int  cycle_count = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;

  function automatic longint eff_side();
    return (shadow_side > MaxSide) ? longint'(MaxSide) : longint'(shadow_side);
  endfunction

  function automatic void shadow_plot(longint x, longint y, logic [23:0] rgb);
    longint s = eff_side();
    if (x < 0 || y < 0 || x >= s || y >= s) return;
    shadow_fb[y * MaxSide + x] = rgb;
  endfunction

  function automatic longint clip_lo(longint v);
    return (v < 0) ? 0 : v;
  endfunction

  function automatic longint clip_hi(longint v);
    return (v > eff_side() - 1) ? eff_side() - 1 : v;
  endfunction

  function automatic longint edge_fn(longint px, longint py, longint qx, longint qy,
                                     longint rx, longint ry);
    return (px - rx) * (qy - ry) - (qx - rx) * (py - ry);
  endfunction

  // Apply one accepted command to the shadow state; queue a pixel for reads
  function automatic void predict_command(in_item_t it);
    longint ax = it.first_x, ay = it.first_y;
    longint bx = it.second_x, by = it.second_y;
    longint cx = it.third_x, cy = it.third_y;
    longint rad = it.radius;
    logic [23:0] rgb = {it.red, it.green, it.blue};
    longint s = eff_side();
    longint x0, x1, y0, y1, d1, d2, d3;
    bit neg, pos;
    logic [23:0] p;
    out_item_t o;
    case (cmd_e'(it.command))
      CmdClear: foreach (shadow_fb[i]) shadow_fb[i] = ClearGray;
      CmdCircle: begin
        for (longint y = clip_lo(cy - rad); y <= clip_hi(cy + rad); y++)
          for (longint x = clip_lo(cx - rad); x <= clip_hi(cx + rad); x++)
            if ((x - cx) * (x - cx) + (y - cy) * (y - cy) <= rad * rad)
              shadow_plot(x, y, rgb);
      end
      CmdRect: begin
        for (longint y = clip_lo(ay); y <= clip_hi(by); y++)
          for (longint x = clip_lo(ax); x <= clip_hi(bx); x++)
            shadow_plot(x, y, rgb);
      end
      CmdTri: begin
        x0 = ax; x1 = ax; y0 = ay; y1 = ay;
        if (bx < x0) x0 = bx; if (cx < x0) x0 = cx;
        if (bx > x1) x1 = bx; if (cx > x1) x1 = cx;
        if (by < y0) y0 = by; if (cy < y0) y0 = cy;
        if (by > y1) y1 = by; if (cy > y1) y1 = cy;
        for (longint y = clip_lo(y0); y <= clip_hi(y1); y++)
          for (longint x = clip_lo(x0); x <= clip_hi(x1); x++) begin
            d1 = edge_fn(x, y, ax, ay, bx, by);
            d2 = edge_fn(x, y, bx, by, cx, cy);
            d3 = edge_fn(x, y, cx, cy, ax, ay);
            neg = (d1 < 0) || (d2 < 0) || (d3 < 0);
            pos = (d1 > 0) || (d2 > 0) || (d3 > 0);
            if (!(neg && pos)) shadow_plot(x, y, rgb);
          end
      end
      CmdDots: begin
        for (longint y = 0; y < s; y++)
          for (longint x = 0; x < s; x++)
            if ((x * 17 + y * 31) % 97 == 0) shadow_plot(x, y, DotColour);
      end
      CmdRead: begin
        p = '0;
        if (ax >= 0 && ay >= 0 && ax < s && ay < s) p = shadow_fb[ay * MaxSide + ax];
        o.pixel_red = p[23:16];
        o.pixel_green = p[15:8];
        o.pixel_blue = p[7:0];
        pixel_expect_q.push_back(o);
      end
      default: ;
    endcase
  endfunction

  // Offer one command, with an optional random gap first
  task automatic send_cmd(in_item_t it, bit allow_gap = 1'b1);
    if (allow_gap && !quiet && $urandom_range(0, 5) == 0) begin
      @(posedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_command(it);
    cmds_sent++;
  endtask

  task automatic idle_input();
    @(posedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic in_item_t mk(cmd_e c, int ax = 0, int ay = 0, int bx = 0, int by = 0,
                                  int cx = 0, int cy = 0, int rad = 0,
                                  logic [23:0] rgb = 24'h000000);
    in_item_t it;
    it.command = c;
    it.first_x = ax[11:0]; it.first_y = ay[11:0];
    it.second_x = bx[11:0]; it.second_y = by[11:0];
    it.third_x = cx[11:0]; it.third_y = cy[11:0];
    it.radius = rad[10:0];
    {it.red, it.green, it.blue} = rgb;
    return it;
  endfunction

  task automatic send_read(int x, int y);
    send_cmd(mk(CmdRead, x, y));
  endtask

  // Marker read: once its pixel arrives, every earlier command has completed
  task automatic drain();
    send_read(0, 0);
    idle_input();
    while (pixel_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_side(int value);
    drain();
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 2'd0; pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    shadow_side = value & 32'h3FF;
  endtask

  // Coordinate mostly near the active square, sometimes anywhere in range
  function automatic int rand_coord();
    if ($urandom_range(0, 9) == 0) return int'($signed(12'($urandom)));
    return int'($urandom_range(0, int'(eff_side() + 8))) - 4;
  endfunction

  function automatic in_item_t rand_cmd();
    in_item_t it;
    int pick = $urandom_range(0, 99);
    int t;
    it.command = 3'($urandom);
    it.radius = 11'($urandom);
    {it.red, it.green, it.blue} = 24'($urandom);
    it.first_x = 12'(rand_coord()); it.first_y = 12'(rand_coord());
    it.second_x = 12'(rand_coord()); it.second_y = 12'(rand_coord());
    it.third_x = 12'(rand_coord()); it.third_y = 12'(rand_coord());
    if ($urandom_range(0, 9) != 0)
      it.radius = 11'($urandom_range(0, int'(eff_side() / 2 + 1)));
    if (pick < 35) it.command = CmdRead;
    else if (pick < 50) begin
      it.command = CmdRect;
      // mostly well-ordered corners
      if ($urandom_range(0, 4) != 0) begin
        if ($signed(it.first_x) > $signed(it.second_x)) begin
          t = it.first_x; it.first_x = it.second_x; it.second_x = 12'(t);
        end
        if ($signed(it.first_y) > $signed(it.second_y)) begin
          t = it.first_y; it.first_y = it.second_y; it.second_y = 12'(t);
        end
      end
    end
    else if (pick < 65) it.command = CmdTri;
    else if (pick < 80) it.command = CmdCircle;
    else if (pick < 85) it.command = CmdDots;
    else if (pick < 92) it.command = $urandom_range(0, 1) ? CmdRsvd6 : CmdRsvd7;
    else if (it.command == CmdClear) it.command = CmdRead;
    return it;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_expect_q.size() == 0) begin
        $error("unexpected pixel %h", out_data_o);
        fail_count++;
      end else begin
        out_item_t e;
        e = pixel_expect_q.pop_front();
        if (out_data_o.pixel_red !== e.pixel_red) begin
          $error("pixel_red exp %h got %h", e.pixel_red, out_data_o.pixel_red);
          fail_count++;
        end
        if (out_data_o.pixel_green !== e.pixel_green) begin
          $error("pixel_green exp %h got %h", e.pixel_green, out_data_o.pixel_green);
          fail_count++;
        end
        if (out_data_o.pixel_blue !== e.pixel_blue) begin
          $error("pixel_blue exp %h got %h", e.pixel_blue, out_data_o.pixel_blue);
          fail_count++;
        end
        pixels_checked++;
      end
    end
  end

  // Receiver stall: random bursts, or one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_shape_rasterizer: FAIL");
      $finish;
    end
  end

  task automatic test_full_frame();
    send_cmd(mk(CmdClear));
    send_read(0, 0);
    send_read(511, 511);
    send_read(512, 0);
    send_read(-1, -2048);
    send_read(2047, 2047);
    send_cmd(mk(CmdRect, 508, 508, 511, 511, 0, 0, 0, 24'hFF00FF));
    send_read(511, 511);
    send_cmd(mk(CmdRect, 20, 5, 10, 8, 0, 0, 0, 24'h123456));   // reversed corners
    send_read(15, 6);
    send_cmd(mk(CmdCircle, 0, 0, 0, 0, 3, 3, 0, 24'hABCDEF));   // radius zero
    send_read(3, 3);
    send_read(4, 3);
    send_cmd(mk(CmdRsvd6, 3, 3));
    send_cmd(mk(CmdRsvd7, 3, 3));
    send_read(3, 3);
  endtask

  task automatic test_oversized_side();
    write_side(1023);
    send_cmd(mk(CmdRect, 500, 2, 2047, 3, 0, 0, 0, 24'h00FF00));
    send_read(511, 3);
    send_read(512, 3);
  endtask

  task automatic test_small_shapes();
    write_side(40);
    send_cmd(mk(CmdTri, 1, 1, 5, 5, 9, 9, 0, 24'h0000FF));       // collinear vertices
    send_read(5, 5);
    send_read(6, 5);
    send_cmd(mk(CmdTri, -2048, -2048, 2047, 0, 0, 2047, 0, 24'h808080));
    send_read(39, 39);
    send_cmd(mk(CmdCircle, 0, 0, 0, 0, -2048, 2047, 2047, 24'hFFFFFF));
    send_cmd(mk(CmdDots));
    send_read(0, 0);
    send_read(40, 1);
    send_cmd(mk(CmdRect, -2048, -2048, 2047, 2047, 0, 0, 0, 24'hFFFFFF));
    send_read(39, 0);
  endtask

  task automatic test_tiny_sides();
    write_side(0);
    send_cmd(mk(CmdRect, 0, 0, 5, 5, 0, 0, 0, 24'h112233));
    send_cmd(mk(CmdDots));
    send_read(0, 0);
    write_side(1);
    send_cmd(mk(CmdRect, 0, 0, 5, 5, 0, 0, 0, 24'h445566));
    send_read(0, 0);
    send_read(1, 0);
  endtask

  task automatic test_random();
    int sides[4] = '{16, 64, 3, 40};
    foreach (sides[k]) begin
      write_side(sides[k]);
      repeat (10) send_cmd(rand_cmd());
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_cmd(mk(CmdRead, i, i), 1'b0);
  endtask

  task automatic test_quiet_tail();
    drain();
    quiet = 1'b1;
    repeat (15) send_cmd(rand_cmd(), 1'b0);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_full_frame();
    test_oversized_side();
    test_small_shapes();
    test_tiny_sides();
    test_random();
    test_backpressure();
    test_quiet_tail();
    idle_input();
    while (pixel_expect_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Covered clear, shapes, dots, reads and reserved commands over side 0..1023;");
    $display("%0d commands sent, %0d pixels checked.", cmds_sent, pixels_checked);
    if (fail_count == 0) begin
      $display("tb_shape_rasterizer: PASS");
    end else begin
      $display("tb_shape_rasterizer: FAIL");
    end
    $finish;
  end
endmodule
